// File: rtl/ssbr_pkg.sv
// Shared types, widths and constants of the stereo stutter block repeater.
package ssbr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_BLOCK   = 4096;
  localparam int ADDR_W      = $clog2(MAX_BLOCK);
  localparam int BSIZE_W     = 13;
  localparam int FRAC_BITS   = 16;
  localparam int PHASE_W     = BSIZE_W + FRAC_BITS;
  localparam int PINC_W      = 21;
  localparam int THR_W       = 17;
  localparam int RAND_W      = 16;
  localparam int GAIN_W      = 16;
  localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
  localparam int ENTRY_W     = 2 * SAMPLE_BITS;
  localparam int STEP_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 21;
  localparam int IN_W        = 2 * SAMPLE_BITS + GAIN_W + 4 * RAND_W;
  localparam int OUT_W       = 2 * SAMPLE_BITS;

  // Highest shift of the compare-subtract reduction for an item and for a
  // block size change.
  localparam logic [STEP_W-1:0] ITEM_TOP_STEP = 4'd5;
  localparam logic [STEP_W-1:0] CFG_TOP_STEP  = 4'd12;

  localparam logic [GAIN_W-1:0]  UNITY_GAIN = 16'h8000;
  localparam logic [BSIZE_W-1:0] BSIZE_RST  = 13'd1024;
  localparam logic [BSIZE_W-1:0] BSIZE_ZERO = 13'd2;
  localparam logic [BSIZE_W-1:0] BSIZE_MAX  = 13'd4096;
  localparam logic [PINC_W-1:0]  PINC_RST   = 21'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_RD_REP,
    ST_WRITE,
    ST_MOD,
    ST_DONE,
    ST_CFG_PH,
    ST_CFG_WI
  } ssbr_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_SIZE = 3'd0,
    CFG_PHASE_INC  = 3'd1,
    CFG_REPEAT_THR = 3'd2,
    CFG_DROP_THR   = 3'd3,
    CFG_WINDOW_EN  = 3'd4
  } ssbr_cfg_idx_t;

  // A write of zero selects two frames, anything above the bank depth
  // saturates to the bank depth.
  function automatic logic [BSIZE_W-1:0] sat_block_size(input logic [BSIZE_W-1:0] v);
    logic [BSIZE_W-1:0] n;
    n = v;
    if (n == '0) begin
      n = BSIZE_ZERO;
    end else if (n > BSIZE_MAX) begin
      n = BSIZE_MAX;
    end
    return n;
  endfunction

endpackage

// File: rtl/stereo_stutter_block_repeater_unit.sv
// Top level of the stereo stutter block repeater: banks, sequencer and shared units.
//
// The block takes one stereo frame per input request and returns one output
// request per frame. Each frame is written into the back bank at the write
// index, scaled by the window gain when window_enable is set (round half up,
// gains above unity clamp to unity); a channel in repeat mode copies the front
// bank entry at the same index instead. In the same step the front bank entry
// at the integer part of the 13.16 read phase is sent out, or zero for a
// channel in dropout, and out_tuser flags a wrap of the read phase, at which
// the repeat and dropout decisions are redrawn from the random words. When the
// back bank fills, the banks swap. Each frame occupies the block from
// acceptance until in_tready rises again: two reads of the single bank read
// port (the output entry, then the repeat entry), one write, six steps of
// the shared compare-subtract unit that reduces the read phase modulo
// block_size<<16, and a step that loads the output register once that
// register is free. A finished result waits in that register, so the next
// frame is taken while the previous result is still pending downstream.
// After reset the block clears both banks, one entry of each per cycle,
// before it accepts the first frame; configuration writes are taken during
// that pass. A write of block_size reduces the read phase and the write
// index to the new size on the same compare-subtract unit and holds cfg_ready
// low while it runs. One 16 by 17 bit multiplier serves both channels.
module stereo_stutter_block_repeater_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Fields from bit 0 up: in_left, in_right, window_gain, rand_repeat_left,
  // rand_repeat_right, rand_drop_left, rand_drop_right (16 bits each).
  input  logic [ssbr_pkg::IN_W-1:0]        in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0 up: out_left, out_right (16 bits each).
  output logic [ssbr_pkg::OUT_W-1:0]       out_tdata,
  // Field: phase_wrapped.
  output logic                             out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ssbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssbr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ssbr_pkg::*;

  // Both banks hold {right, left} per entry.
  logic [ENTRY_W-1:0] bank_a [MAX_BLOCK];
  logic [ENTRY_W-1:0] bank_b [MAX_BLOCK];
  logic [ENTRY_W-1:0] a_q_r, b_q_r;

  ssbr_state_t state_r, state_nxt;

  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_idx_r, clr_idx_nxt;

  logic [BSIZE_W-1:0] block_size_r, block_size_nxt;
  logic [PINC_W-1:0]  phase_inc_r, phase_inc_nxt;
  logic [THR_W-1:0]   rep_thr_r, rep_thr_nxt;
  logic [THR_W-1:0]   drop_thr_r, drop_thr_nxt;
  logic               win_en_r, win_en_nxt;

  logic               front_sel_r, front_sel_nxt;
  logic [PHASE_W-1:0] read_phase_r, read_phase_nxt;
  logic [ADDR_W-1:0]  write_index_r, write_index_nxt;
  logic [3:0]         flags_r, flags_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_wrap_r;

  // Latched frame.
  logic signed [SAMPLE_BITS-1:0] smp_l_r, smp_r_r;
  logic [GAIN_W-1:0]             gain_r;
  logic [RAND_W-1:0]             rnd_rep_l_r, rnd_rep_r_r, rnd_drop_l_r, rnd_drop_r_r;
  logic [GAIN_W-1:0]             gain_in;

  // Working registers of one frame.
  logic signed [PROD_W-1:0]      prod_l_r, prod_r_r;
  logic [SAMPLE_BITS-1:0]        hold_l_r, hold_r_r;
  logic [PHASE_W-1:0]            rem_r;
  logic [STEP_W-1:0]             step_r;
  logic                          wrapped_r;

  logic in_fire, cfg_fire, out_free;

  // Shared compare-subtract unit.
  logic [PHASE_W-1:0] modulus, rem_shift, sub_val, unit_rem;
  logic               unit_ge;
  logic [PHASE_W-1:0] phase_sum;

  // Shared multiplier and rounding.
  logic signed [SAMPLE_BITS-1:0] mul_in;
  logic signed [PROD_W-1:0]      mul_out, rnd_l, rnd_r;

  // Bank access.
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [ENTRY_W-1:0] wr_data, front_q;
  logic               wr_en_a, wr_en_b;
  logic [SAMPLE_BITS-1:0] wr_l, wr_r;
  logic [BSIZE_W-1:0] wi_inc;

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_tready;

  // A pending configuration write goes first; frames wait for the clear pass.
  assign in_tready = (state_r == ST_IDLE) && !clr_busy_r && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_wrap_r;

  // The unit tests rem >= modulus<<step by comparing rem>>step with the
  // modulus, so the shifted divisor never needs more bits than the remainder.
  assign modulus   = {block_size_r, {FRAC_BITS{1'b0}}};
  assign rem_shift = rem_r >> step_r;
  assign sub_val   = modulus << step_r;
  assign unit_ge   = (rem_shift >= modulus);
  assign unit_rem  = unit_ge ? (rem_r - sub_val) : rem_r;

  assign phase_sum = read_phase_r + PHASE_W'(phase_inc_r);

  assign gain_in = in_tdata[2*SAMPLE_BITS +: GAIN_W];

  assign mul_in  = (state_r == ST_RD_OUT) ? smp_l_r : smp_r_r;
  assign mul_out = mul_in * $signed({1'b0, gain_r});
  assign rnd_l   = (prod_l_r + PROD_W'(16384)) >>> 15;
  assign rnd_r   = (prod_r_r + PROD_W'(16384)) >>> 15;

  assign front_q = front_sel_r ? b_q_r : a_q_r;
  assign wr_l    = flags_r[0] ? front_q[SAMPLE_BITS-1:0] : rnd_l[SAMPLE_BITS-1:0];
  assign wr_r    = flags_r[1] ? front_q[ENTRY_W-1:SAMPLE_BITS] : rnd_r[SAMPLE_BITS-1:0];

  // The output entry is read first, the repeat source second.
  assign rd_addr = (state_r == ST_RD_OUT) ? read_phase_r[FRAC_BITS +: ADDR_W]
                                          : write_index_r;
  assign wr_addr = clr_busy_r ? clr_idx_r : write_index_r;
  assign wr_data = clr_busy_r ? '0 : {wr_r, wr_l};
  assign wr_en_a = clr_busy_r || ((state_r == ST_WRITE) && front_sel_r);
  assign wr_en_b = clr_busy_r || ((state_r == ST_WRITE) && !front_sel_r);

  assign wi_inc = {1'b0, write_index_r} + BSIZE_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en_a) begin
      bank_a[wr_addr] <= wr_data;
    end
    a_q_r <= bank_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en_b) begin
      bank_b[wr_addr] <= wr_data;
    end
    b_q_r <= bank_b[rd_addr];
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_fire && (cfg_index == CFG_BLOCK_SIZE)) begin
          state_nxt = ST_CFG_PH;
        end else if (in_fire) begin
          state_nxt = ST_RD_OUT;
        end
      end
      ST_RD_OUT: state_nxt = ST_RD_REP;
      ST_RD_REP: state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_MOD;
      ST_MOD: begin
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CFG_PH: begin
        if (step_r == '0) begin
          state_nxt = ST_CFG_WI;
        end
      end
      ST_CFG_WI: begin
        if (step_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: control and architectural state updates.
  always_comb begin
    clr_busy_nxt    = clr_busy_r;
    clr_idx_nxt     = clr_idx_r;
    block_size_nxt  = block_size_r;
    phase_inc_nxt   = phase_inc_r;
    rep_thr_nxt     = rep_thr_r;
    drop_thr_nxt    = drop_thr_r;
    win_en_nxt      = win_en_r;
    front_sel_nxt   = front_sel_r;
    read_phase_nxt  = read_phase_r;
    write_index_nxt = write_index_r;
    flags_nxt       = flags_r;
    out_valid_nxt   = out_valid_r;

    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + ADDR_W'(1);
      if (clr_idx_r == '1) begin
        clr_busy_nxt = 1'b0;
      end
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_fire) begin
      case (cfg_index)
        CFG_BLOCK_SIZE: block_size_nxt = sat_block_size(cfg_data[BSIZE_W-1:0]);
        CFG_PHASE_INC:  phase_inc_nxt  = cfg_data[PINC_W-1:0];
        CFG_REPEAT_THR: rep_thr_nxt    = cfg_data[THR_W-1:0];
        CFG_DROP_THR:   drop_thr_nxt   = cfg_data[THR_W-1:0];
        CFG_WINDOW_EN:  win_en_nxt     = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          read_phase_nxt = rem_r;
          if (wrapped_r) begin
            flags_nxt[0] = ({1'b0, rnd_rep_l_r} < rep_thr_r);
            flags_nxt[1] = ({1'b0, rnd_rep_r_r} < rep_thr_r);
            flags_nxt[2] = ({1'b0, rnd_drop_l_r} < drop_thr_r);
            flags_nxt[3] = ({1'b0, rnd_drop_r_r} < drop_thr_r);
          end
          if (wi_inc >= block_size_r) begin
            write_index_nxt = '0;
            front_sel_nxt   = !front_sel_r;
          end else begin
            write_index_nxt = wi_inc[ADDR_W-1:0];
          end
        end
      end
      ST_CFG_PH: begin
        if (step_r == '0) begin
          read_phase_nxt = unit_rem;
        end
      end
      ST_CFG_WI: begin
        if (step_r == '0) begin
          write_index_nxt = unit_rem[FRAC_BITS +: ADDR_W];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      clr_busy_r    <= 1'b1;
      clr_idx_r     <= '0;
      block_size_r  <= BSIZE_RST;
      phase_inc_r   <= PINC_RST;
      rep_thr_r     <= '0;
      drop_thr_r    <= '0;
      win_en_r      <= 1'b0;
      front_sel_r   <= 1'b0;
      read_phase_r  <= '0;
      write_index_r <= '0;
      flags_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_busy_r    <= clr_busy_nxt;
      clr_idx_r     <= clr_idx_nxt;
      block_size_r  <= block_size_nxt;
      phase_inc_r   <= phase_inc_nxt;
      rep_thr_r     <= rep_thr_nxt;
      drop_thr_r    <= drop_thr_nxt;
      win_en_r      <= win_en_nxt;
      front_sel_r   <= front_sel_nxt;
      read_phase_r  <= read_phase_nxt;
      write_index_r <= write_index_nxt;
      flags_r       <= flags_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_l_r      <= in_tdata[0 +: SAMPLE_BITS];
      smp_r_r      <= in_tdata[SAMPLE_BITS +: SAMPLE_BITS];
      rnd_rep_l_r  <= in_tdata[2*SAMPLE_BITS + GAIN_W +: RAND_W];
      rnd_rep_r_r  <= in_tdata[2*SAMPLE_BITS + GAIN_W + RAND_W +: RAND_W];
      rnd_drop_l_r <= in_tdata[2*SAMPLE_BITS + GAIN_W + 2*RAND_W +: RAND_W];
      rnd_drop_r_r <= in_tdata[2*SAMPLE_BITS + GAIN_W + 3*RAND_W +: RAND_W];
      if (win_en_r && (gain_in < UNITY_GAIN)) begin
        gain_r <= gain_in;
      end else begin
        gain_r <= UNITY_GAIN;
      end
    end

    if (state_r == ST_RD_OUT) begin
      prod_l_r  <= mul_out;
      rem_r     <= phase_sum;
      wrapped_r <= (phase_sum >= modulus);
      step_r    <= ITEM_TOP_STEP;
    end

    if (state_r == ST_RD_REP) begin
      prod_r_r <= mul_out;
      hold_l_r <= flags_r[2] ? '0 : front_q[SAMPLE_BITS-1:0];
      hold_r_r <= flags_r[3] ? '0 : front_q[ENTRY_W-1:SAMPLE_BITS];
    end

    if ((state_r == ST_MOD) || (state_r == ST_CFG_PH) || (state_r == ST_CFG_WI)) begin
      rem_r  <= unit_rem;
      step_r <= step_r - STEP_W'(1);
    end

    // After the phase, the write index runs through the same unit in the
    // upper bits, which is the same reduction scaled by 2^16.
    if ((state_r == ST_CFG_PH) && (step_r == '0)) begin
      rem_r  <= {1'b0, write_index_r, {FRAC_BITS{1'b0}}};
      step_r <= CFG_TOP_STEP;
    end

    if (cfg_fire && (cfg_index == CFG_BLOCK_SIZE)) begin
      rem_r  <= read_phase_r;
      step_r <= CFG_TOP_STEP;
    end

    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= {hold_r_r, hold_l_r};
      out_wrap_r <= wrapped_r;
    end
  end

  a_phase_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (read_phase_r < modulus))
    else $error("read phase not below block_size<<16 while idle");

  a_windex_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ({1'b0, write_index_r} < block_size_r))
    else $error("write index not below block size while idle");

  a_bsize_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (block_size_r != '0) && (block_size_r <= BSIZE_MAX))
    else $error("block size out of range");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> out_tvalid)
    else $error("finished frame did not reach the output register");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_busy_r && (clr_idx_r == '1)) |=> !clr_busy_r)
    else $error("bank clear pass did not end after the last entry");

endmodule
